/* hdl/fpst_pkg.sv */
// Shared constants and types for the Fenwick prefix-sum table.
`timescale 1ns / 1ps
`default_nettype none
package fpst_pkg;

  localparam int TABLE_SIZE_DEF = 1024;
  localparam int POS_W          = 10;
  localparam int SUM_W          = 32;
  localparam int ACT_W          = 2;

  typedef logic [ACT_W-1:0] action_t;

  localparam action_t ACT_ADD   = ACT_W'(0);
  localparam action_t ACT_QUERY = ACT_W'(1);
  localparam action_t ACT_CLEAR = ACT_W'(2);

  // Item travelling down the chain of level cells.
  typedef struct packed {
    logic                    valid;
    action_t                 action;
    logic signed [SUM_W-1:0] delta;
  } item_t;

  // Running prefix sum travelling one stage behind the item.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } res_t;

endpackage
`default_nettype wire

/* hdl/fpst_in_if.sv */
// Input channel: action, position and delta with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface fpst_in_if;
  logic                                   valid;
  logic                                   ready;
  fpst_pkg::action_t                      action;
  logic [fpst_pkg::POS_W-1:0]             position;
  logic signed [fpst_pkg::SUM_W-1:0]      delta;

  modport source (output valid, output action, output position, output delta, input ready);
  modport sink   (input valid, input action, input position, input delta, output ready);
endinterface
`default_nettype wire

/* hdl/fpst_out_if.sv */
// Output channel: prefix sum with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface fpst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fpst_pkg::SUM_W-1:0] prefix_sum;

  modport source (output valid, output prefix_sum, input ready);
  modport sink   (input valid, input prefix_sum, output ready);
endinterface
`default_nettype wire

/* hdl/fpst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fpst_ram #(
  parameter int WIDTH = fpst_pkg::SUM_W,
  parameter int DEPTH = fpst_pkg::TABLE_SIZE_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hdl/fpst_cell.sv */
// One tree level: holds the counters whose index has its lowest set bit at LEVEL.
`timescale 1ns / 1ps
`default_nettype none
module fpst_cell #(
  parameter int TABLE_SIZE = fpst_pkg::TABLE_SIZE_DEF,
  parameter int LEVEL      = 0,
  parameter int IW         = fpst_pkg::POS_W + 1,
  parameter int CW         = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fpst_pkg::item_t       tok_in,
  input  logic [IW-1:0]         idx_in,
  output fpst_pkg::item_t       tok_out,
  output logic [IW-1:0]         idx_out,
  input  fpst_pkg::res_t        res_in,
  output fpst_pkg::res_t        res_out,
  input  logic                  sweep_en,
  input  logic [CW-1:0]         sweep_addr
);

  localparam int DEPTH = ((TABLE_SIZE - 1) >> (LEVEL + 1)) + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] STEP = IW'(1) << LEVEL;
  localparam logic [IW-1:0] TS   = IW'(TABLE_SIZE);

  logic                         is_add;
  logic                         is_query;
  logic                         hit;
  logic [IW-1:0]                idx_shift;
  logic [AW-1:0]                rd_addr;
  logic [IW-1:0]                idx_next;

  fpst_pkg::item_t              b_tok;
  logic                         b_hit;
  logic [AW-1:0]                b_addr;
  logic [fpst_pkg::SUM_W-1:0]   rd_data;
  logic [fpst_pkg::SUM_W-1:0]   acc;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [fpst_pkg::SUM_W-1:0]   wr_data;

  // Lookup side: address and next index for the item now at this level.
  always_comb begin
    is_add    = (tok_in.action == fpst_pkg::ACT_ADD);
    is_query  = (tok_in.action == fpst_pkg::ACT_QUERY);
    hit       = tok_in.valid && idx_in[LEVEL] && ((is_add && (idx_in < TS)) || is_query);
    idx_shift = idx_in >> (LEVEL + 1);
    rd_addr   = idx_shift[AW-1:0];
    idx_next  = idx_in;
    if (is_add && idx_in[LEVEL]) begin
      idx_next = idx_in + STEP;
    end else if (is_query) begin
      idx_next = idx_in & ~STEP;
    end
  end

  // Data side: read data is back in the cycle after the lookup; accumulate, write back, or zero during the sweep.
  always_comb begin
    acc = res_in.sum;
    if (b_hit && (b_tok.action == fpst_pkg::ACT_QUERY)) begin
      acc = res_in.sum + rd_data;
    end
    if (sweep_en) begin
      wr_en   = ({1'b0, sweep_addr} < (CW + 1)'(DEPTH));
      wr_addr = sweep_addr[AW-1:0];
      wr_data = '0;
    end else begin
      wr_en   = b_hit && (b_tok.action == fpst_pkg::ACT_ADD);
      wr_addr = b_addr;
      wr_data = rd_data + $unsigned(b_tok.delta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      b_tok.valid   <= 1'b0;
      b_hit         <= 1'b0;
      res_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      b_tok.valid   <= tok_in.valid;
      b_hit         <= hit;
      res_out.valid <= b_tok.valid;
    end
    tok_out.action <= tok_in.action;
    tok_out.delta  <= tok_in.delta;
    idx_out        <= idx_next;
    b_tok.action   <= tok_in.action;
    b_tok.delta    <= tok_in.delta;
    b_addr         <= rd_addr;
    res_out.sum    <= acc;
  end

  fpst_ram #(
    .WIDTH (fpst_pkg::SUM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

/* hdl/fenwick_prefix_sum_table.sv */
// Top level: Fenwick prefix-sum table built as a chain of per-level cells.
//
//   channel  dir  handshake      payload
//   items    in   valid/ready    action, position, delta
//   sums     out  valid/ready    prefix_sum
//
// Add and query run down a chain of LEVELS = clog2(TABLE_SIZE) cells, one
// RAM read per cell and, for an add, at most one write-back; no new add or
// query is taken until the previous one has left the chain and its result
// can go out. Clear and reset run a zeroing sweep over all level RAMs in
// parallel, with no transfer in; a clear then returns a zero sum.
// The output register plus one pending slot decouple a stalled sink.
`timescale 1ns / 1ps
`default_nettype none
module fenwick_prefix_sum_table #(
  parameter int TABLE_SIZE = fpst_pkg::TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fpst_in_if.sink           items,
  fpst_out_if.source        sums
);

  localparam int LEVELS = $clog2(TABLE_SIZE);
  localparam int IW     = ((fpst_pkg::POS_W > LEVELS) ? fpst_pkg::POS_W : LEVELS) + 1;
  localparam int DEPTH0 = ((TABLE_SIZE - 1) >> 1) + 1;
  localparam int CW     = (DEPTH0 > 1) ? $clog2(DEPTH0) : 1;
  localparam logic [IW-1:0] TS      = IW'(TABLE_SIZE);
  localparam logic [IW-1:0] TS_LAST = IW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] SWEEP_LAST = CW'(DEPTH0 - 1);

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  state_t                       state, state_next;
  logic [CW-1:0]                sweep_cnt, sweep_cnt_next;
  logic                         sweep_reply, sweep_reply_next;
  logic                         sweep_last;
  logic                         out_valid, out_valid_next;
  logic [fpst_pkg::SUM_W-1:0]   out_sum, out_sum_next;
  logic                         pend_valid, pend_valid_next;
  logic [fpst_pkg::SUM_W-1:0]   pend_sum, pend_sum_next;

  logic                         in_xfer;
  logic                         is_clear;
  logic                         done;
  logic                         out_free;
  logic                         deliver;
  logic [fpst_pkg::SUM_W-1:0]   dval;
  logic [IW-1:0]                pos_ext;

  fpst_pkg::item_t              tok [LEVELS+1];
  logic [IW-1:0]                idx [LEVELS+1];
  fpst_pkg::res_t               res [LEVELS+1];

  assign is_clear   = (items.action == fpst_pkg::ACT_CLEAR);
  assign done       = (state == ST_RUN) && res[LEVELS].valid;
  assign out_free   = !out_valid || sums.ready;
  assign sweep_last = (sweep_cnt == SWEEP_LAST);
  assign items.ready = !pend_valid &&
                       ((state == ST_IDLE) || (done && out_free));
  assign in_xfer    = items.valid && items.ready;
  assign pos_ext    = IW'(items.position);

  assign sums.valid      = out_valid;
  assign sums.prefix_sum = $signed(out_sum);

  // Chain head: the accepted add or query enters level 0 directly.
  always_comb begin
    tok[0].valid  = in_xfer && !is_clear;
    tok[0].action = items.action;
    tok[0].delta  = items.delta;
    if ((items.action == fpst_pkg::ACT_QUERY) && (pos_ext >= TS)) begin
      idx[0] = TS_LAST;
    end else begin
      idx[0] = pos_ext;
    end
    res[0].valid = 1'b0;
    res[0].sum   = '0;
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    fpst_cell #(
      .TABLE_SIZE (TABLE_SIZE),
      .LEVEL      (k),
      .IW         (IW),
      .CW         (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[k]),
      .idx_in     (idx[k]),
      .tok_out    (tok[k+1]),
      .idx_out    (idx[k+1]),
      .res_in     (res[k]),
      .res_out    (res[k+1]),
      .sweep_en   (state == ST_SWEEP),
      .sweep_addr (sweep_cnt)
    );
  end

  always_comb begin
    state_next       = state;
    sweep_cnt_next   = sweep_cnt;
    sweep_reply_next = sweep_reply;
    deliver          = 1'b0;
    dval             = '0;
    case (state)
      ST_SWEEP: begin
        sweep_cnt_next = sweep_cnt + CW'(1);
        if (sweep_last) begin
          state_next       = ST_IDLE;
          deliver          = sweep_reply;
          sweep_reply_next = 1'b0;
        end
      end
      ST_IDLE: begin
        state_next = ST_IDLE;
      end
      ST_RUN: begin
        if (done) begin
          state_next = ST_IDLE;
          deliver    = 1'b1;
          dval       = res[LEVELS].sum;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (in_xfer) begin
      if (is_clear) begin
        state_next       = ST_SWEEP;
        sweep_cnt_next   = '0;
        sweep_reply_next = 1'b1;
      end else begin
        state_next = ST_RUN;
      end
    end
  end

  // Output register with one pending slot behind it.
  always_comb begin
    out_valid_next  = out_valid;
    out_sum_next    = out_sum;
    pend_valid_next = pend_valid;
    pend_sum_next   = pend_sum;
    if (out_free) begin
      if (pend_valid) begin
        out_valid_next  = 1'b1;
        out_sum_next    = pend_sum;
        pend_valid_next = 1'b0;
      end else if (deliver) begin
        out_valid_next = 1'b1;
        out_sum_next   = dval;
      end else begin
        out_valid_next = 1'b0;
      end
    end else if (deliver) begin
      pend_valid_next = 1'b1;
      pend_sum_next   = dval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_cnt   <= '0;
      sweep_reply <= 1'b0;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      sweep_cnt   <= sweep_cnt_next;
      sweep_reply <= sweep_reply_next;
      out_valid   <= out_valid_next;
      pend_valid  <= pend_valid_next;
    end
    out_sum  <= out_sum_next;
    pend_sum <= pend_sum_next;
  end

endmodule
`default_nettype wire

/* hdl/fpst_checker.sv */
// Port-level checks for the Fenwick prefix-sum table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpst_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input fpst_pkg::action_t action,
  input logic              out_valid,
  input logic              out_ready
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (pending != 2'd0))
    else $error("result transfer with no item outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more items outstanding than the block can hold");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (action != fpst_pkg::ACT_CLEAR)) |=> !in_ready)
    else $error("input ready right after an add or query transfer");

  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !in_ready)
    else $error("input ready before the reset sweep finished");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind fenwick_prefix_sum_table fpst_checker u_fpst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .action    (items.action),
  .out_valid (sums.valid),
  .out_ready (sums.ready)
);
`default_nettype wire
